[sv/kdcl_pkg.sv]
// ----------------------------------------------------------------------------
// kdcl_pkg
// Shared widths, reset values, status codes and the key-to-ASCII table of the
// keypad debounce and code lock block.
// ----------------------------------------------------------------------------
package kdcl_pkg;

    localparam int SCAN_W   = 16;
    localparam int KEY_W    = 7;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // configuration register indexes (paddr[2])
    localparam logic REG_CODE_ONE = 1'b0;
    localparam logic REG_CODE_TWO = 1'b1;

    // reset values of the code registers: '1' and '2'
    localparam logic [KEY_W-1:0] CODE_ONE_RESET = 7'd49;
    localparam logic [KEY_W-1:0] CODE_TWO_RESET = 7'd50;

    localparam logic [KEY_W-1:0] KEY_NONE = 7'd0;

    // lock verdict codes
    localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ACCEPT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

    // scan bit position -> ASCII, bit 0 first
    localparam logic [KEY_W-1:0] KEY_ASCII [SCAN_W] = '{
        7'h2a, 7'h30, 7'h23, 7'h44,   // * 0 # D
        7'h37, 7'h38, 7'h39, 7'h43,   // 7 8 9 C
        7'h34, 7'h35, 7'h36, 7'h42,   // 4 5 6 B
        7'h31, 7'h32, 7'h33, 7'h41    // 1 2 3 A
    };

endpackage

[sv/kdcl_encode.sv]
// ----------------------------------------------------------------------------
// kdcl_encode
// Debounces the two scans, keeps the held-key state and encodes the lowest
// newly pressed key as ASCII (zero when none).
// ----------------------------------------------------------------------------
module kdcl_encode (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [kdcl_pkg::SCAN_W-1:0] i_scan_early,
    input  logic [kdcl_pkg::SCAN_W-1:0] i_scan_late,
    output logic [kdcl_pkg::KEY_W-1:0]  o_key_code
);
    import kdcl_pkg::*;

    logic [SCAN_W-1:0] r_held;
    logic [SCAN_W-1:0] n_held;
    logic [SCAN_W-1:0] fresh;
    logic [SCAN_W-1:0] lowest;

    // debounce and rising-edge detect
    always_comb begin
        n_held = i_scan_early & i_scan_late;
        fresh  = n_held & ~r_held;
        lowest = fresh & (~fresh + {{(SCAN_W-1){1'b0}}, 1'b1});
    end

    // one-hot lowest key selects its code
    always_comb begin
        o_key_code = KEY_NONE;
        for (int i = 0; i < SCAN_W; i++) begin
            if (lowest[i]) begin
                o_key_code = o_key_code | KEY_ASCII[i];
            end
        end
    end

    // held keys advance on every transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_accept) begin
            r_held <= n_held;
        end
    end

endmodule

[sv/kdcl_lock.sv]
// ----------------------------------------------------------------------------
// kdcl_lock
// Two-key code lock: collects the first and second reported keys, compares
// them with the code registers and gives the verdict on the next transaction.
// ----------------------------------------------------------------------------
module kdcl_lock (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [kdcl_pkg::KEY_W-1:0]    i_key_code,
    input  logic [kdcl_pkg::KEY_W-1:0]    i_code_one,
    input  logic [kdcl_pkg::KEY_W-1:0]    i_code_two,
    output logic [kdcl_pkg::STATUS_W-1:0] o_status
);
    import kdcl_pkg::*;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_MATCH,
        PH_MISMATCH
    } t_phase;

    t_phase           r_phase;
    t_phase           n_phase;
    logic [KEY_W-1:0] r_first;
    logic [KEY_W-1:0] n_first;
    logic             key_seen;

    // next phase and verdict for the current transaction
    always_comb begin
        key_seen = (i_key_code != KEY_NONE);
        n_phase  = r_phase;
        n_first  = r_first;
        o_status = STATUS_NONE;
        case (r_phase)
            PH_FIRST: begin
                if (key_seen) begin
                    n_first = i_key_code;
                    n_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                if (key_seen) begin
                    n_phase = ((r_first == i_code_one) && (i_key_code == i_code_two))
                              ? PH_MATCH : PH_MISMATCH;
                end
            end
            PH_MATCH: begin
                o_status = STATUS_ACCEPT;
                n_phase  = PH_FIRST;
            end
            default: begin
                o_status = STATUS_REJECT;
                n_phase  = PH_FIRST;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_first <= KEY_NONE;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_first <= n_first;
        end
    end

    // a verdict phase always returns to waiting for the first key
    a_verdict_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (r_phase == PH_MATCH || r_phase == PH_MISMATCH))
        |=> (r_phase == PH_FIRST))
        else $error("lock did not return to first-key phase after verdict");

    // first key is captured when leaving the first-key phase
    a_first_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_FIRST && i_key_code != KEY_NONE)
        |=> (r_phase == PH_SECOND && r_first == $past(i_key_code)))
        else $error("first key not captured");

endmodule

[sv/keypad_debounce_edge_code_lock_top.sv]
// ----------------------------------------------------------------------------
// keypad_debounce_edge_code_lock_top
// Keypad debounce, newly-pressed-key encoder and two-key code lock with an
// APB-style code register port and a two-entry output buffer.
// ----------------------------------------------------------------------------
// A result is registered in the output register, or the skid entry if held.
// Throughput: one transaction per cycle while the input is not stalled; the
//   single-pass logic from the input ports to the output register sets it.
// Input stalls only when both output buffer entries hold results.
// Reset (synchronous, active low) clears held keys, lock phase, buffer valids
//   and loads the codes '1' and '2'.
module keypad_debounce_edge_code_lock_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [kdcl_pkg::SCAN_W-1:0]   i_scan_early,
    input  logic [kdcl_pkg::SCAN_W-1:0]   i_scan_late,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [kdcl_pkg::KEY_W-1:0]    o_key_code,
    output logic [kdcl_pkg::STATUS_W-1:0] o_code_status,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kdcl_pkg::ADDR_W-1:0]   paddr,
    input  logic [kdcl_pkg::DATA_W-1:0]   pwdata,
    output logic [kdcl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import kdcl_pkg::*;

    logic [KEY_W-1:0]    r_code_one;
    logic [KEY_W-1:0]    r_code_two;
    logic                cfg_write;

    logic                in_accept;
    logic                out_take;
    logic [KEY_W-1:0]    key_code;
    logic [STATUS_W-1:0] status;

    logic                r_out_valid;
    logic [KEY_W-1:0]    r_out_key;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_skid_valid;
    logic [KEY_W-1:0]    r_skid_key;
    logic [STATUS_W-1:0] r_skid_status;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_CODE_TWO)
                       ? {{(DATA_W-KEY_W){1'b0}}, r_code_two}
                       : {{(DATA_W-KEY_W){1'b0}}, r_code_one};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_one <= CODE_ONE_RESET;
            r_code_two <= CODE_TWO_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_CODE_ONE) begin
                r_code_one <= pwdata[KEY_W-1:0];
            end else begin
                r_code_two <= pwdata[KEY_W-1:0];
            end
        end
    end

    // handshakes
    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    kdcl_encode u_encode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_scan_early (i_scan_early),
        .i_scan_late  (i_scan_late),
        .o_key_code   (key_code)
    );

    kdcl_lock u_lock (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_key_code (key_code),
        .i_code_one (r_code_one),
        .i_code_two (r_code_two),
        .o_status   (status)
    );

    // two-entry output buffer: output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out_valid   <= 1'b1;
                    r_out_key     <= r_skid_key;
                    r_out_status  <= r_skid_status;
                    r_skid_valid  <= in_accept;
                    r_skid_key    <= key_code;
                    r_skid_status <= status;
                end else begin
                    r_out_valid  <= in_accept;
                    r_out_key    <= key_code;
                    r_out_status <= status;
                end
            end else if (in_accept) begin
                r_skid_valid  <= 1'b1;
                r_skid_key    <= key_code;
                r_skid_status <= status;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_key_code    = r_out_key;
    assign o_code_status = r_out_status;

    // skid entry is only ever filled behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    // a transaction accepted while the output is held lands in the skid entry
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("transaction lost while output held");

    // status code 3 is never produced
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_status == STATUS_NONE || r_out_status == STATUS_ACCEPT
                         || r_out_status == STATUS_REJECT))
        else $error("illegal code status");

endmodule

[sim/kdcl_lock_checker.sv]
// ----------------------------------------------------------------------------
// kdcl_lock_checker
// Watches the scan, result and register channels of the keypad code lock,
// keeps its own copy of the debounce and lock state, and compares every
// result transaction against the oldest predicted one.
// ----------------------------------------------------------------------------
module kdcl_lock_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // scan channel
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [kdcl_pkg::SCAN_W-1:0]   i_scan_early,
    input  logic [kdcl_pkg::SCAN_W-1:0]   i_scan_late,
    // result channel
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [kdcl_pkg::KEY_W-1:0]    i_key_code,
    input  logic [kdcl_pkg::STATUS_W-1:0] i_code_status,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kdcl_pkg::ADDR_W-1:0]   paddr,
    input  logic [kdcl_pkg::DATA_W-1:0]   pwdata,
    input  logic                          pready,
    // totals for the top
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count,
    output int                            o_accept_count,
    output int                            o_reject_count
);
    import kdcl_pkg::*;

    typedef enum logic [1:0] {
        LOCK_WAIT_FIRST,
        LOCK_WAIT_SECOND,
        LOCK_DISCARD_MATCH,
        LOCK_DISCARD_MISMATCH
    } t_lock_step;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [STATUS_W-1:0] status;
    } t_lock_result;

    // predictor state
    logic [SCAN_W-1:0] held_keys;
    t_lock_step        lock_step;
    logic [KEY_W-1:0]  first_key;
    logic [KEY_W-1:0]  code_one;
    logic [KEY_W-1:0]  code_two;

    t_lock_result      pending_results[$];
    int                fail_count;
    int                result_count;
    int                accept_count;
    int                reject_count;

    // one line per mismatch, every one counted
    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 result_count, what, got, want);
        fail_count++;
    endtask

    // debounce, new-key encode and lock step for one scan transaction
    task automatic predict_scan(input logic [SCAN_W-1:0] early,
                                input logic [SCAN_W-1:0] late,
                                output t_lock_result res);
        logic [SCAN_W-1:0] debounced;
        logic [SCAN_W-1:0] fresh;
        int                i;
        debounced = early & late;
        fresh     = debounced & ~held_keys;
        held_keys = debounced;
        res.key   = KEY_NONE;
        // walk high to low so the lowest set bit wins
        for (i = SCAN_W - 1; i >= 0; i--)
            if (fresh[i])
                res.key = KEY_ASCII[i];
        res.status = STATUS_NONE;
        case (lock_step)
            LOCK_WAIT_FIRST: begin
                if (res.key != KEY_NONE) begin
                    first_key = res.key;
                    lock_step = LOCK_WAIT_SECOND;
                end
            end
            LOCK_WAIT_SECOND: begin
                // verdict is latched here, later register writes do not matter
                if (res.key != KEY_NONE)
                    lock_step = (first_key == code_one && res.key == code_two) ?
                                LOCK_DISCARD_MATCH : LOCK_DISCARD_MISMATCH;
            end
            LOCK_DISCARD_MATCH: begin
                res.status = STATUS_ACCEPT;
                lock_step  = LOCK_WAIT_FIRST;
            end
            default: begin
                res.status = STATUS_REJECT;
                lock_step  = LOCK_WAIT_FIRST;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_lock_result want;
        t_lock_result pred;
        if (!i_rst_n) begin
            held_keys = '0;
            lock_step = LOCK_WAIT_FIRST;
            first_key = KEY_NONE;
            code_one  = CODE_ONE_RESET;
            code_two  = CODE_TWO_RESET;
            pending_results.delete();
            fail_count   = 0;
            result_count = 0;
            accept_count = 0;
            reject_count = 0;
        end else begin
            // result side first: it can only belong to an earlier transaction
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("arrived with nothing pending, key", i_key_code, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_key_code !== want.key)
                        flag_mismatch("key_code", i_key_code, want.key);
                    if (i_code_status !== want.status)
                        flag_mismatch("code_status", i_code_status, want.status);
                    if (want.status == STATUS_ACCEPT)
                        accept_count++;
                    if (want.status == STATUS_REJECT)
                        reject_count++;
                end
                result_count++;
            end
            // scan side
            if (i_in_valid && !i_in_stall) begin
                predict_scan(i_scan_early, i_scan_late, pred);
                pending_results.push_back(pred);
            end
            // register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_CODE_ONE)
                    code_one = pwdata[KEY_W-1:0];
                else
                    code_two = pwdata[KEY_W-1:0];
            end
        end
        o_fail_count   <= fail_count;
        o_pending      <= pending_results.size();
        o_result_count <= result_count;
        o_accept_count <= accept_count;
        o_reject_count <= reject_count;
    end

endmodule

[sim/tb_keypad_debounce_edge_code_lock_top.sv]
// ----------------------------------------------------------------------------
// tb_keypad_debounce_edge_code_lock_top
// Drives scan transactions, register writes and result back-pressure into the
// keypad code lock; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_keypad_debounce_edge_code_lock_top;
    import kdcl_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 430;
    localparam int HOLD_CYCLES   = 300;
    localparam int DUT_LATENCY   = 1;
    localparam int KEY_BIT_ONE   = 12;   // '1'
    localparam int KEY_BIT_TWO   = 13;   // '2'
    localparam int KEY_BIT_A     = 15;   // 'A'

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [SCAN_W-1:0]   i_scan_early;
    logic [SCAN_W-1:0]   i_scan_late;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [KEY_W-1:0]    o_key_code;
    logic [STATUS_W-1:0] o_code_status;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int                  fail_count;
    int                  results_pending;
    int                  result_count;
    int                  accept_count;
    int                  reject_count;

    int                  scans_sent;
    int                  code_settings;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  hold_requests;
    int                  holds_served;
    int                  hold_left;
    int                  cycle_count;
    logic [KEY_W-1:0]    code_one_now;
    logic [KEY_W-1:0]    code_two_now;

    keypad_debounce_edge_code_lock_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_scan_early  (i_scan_early),
        .i_scan_late   (i_scan_late),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_key_code    (o_key_code),
        .o_code_status (o_code_status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    kdcl_lock_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_scan_early   (i_scan_early),
        .i_scan_late    (i_scan_late),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_key_code     (o_key_code),
        .i_code_status  (o_code_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_fail_count   (fail_count),
        .o_pending      (results_pending),
        .o_result_count (result_count),
        .o_accept_count (accept_count),
        .o_reject_count (reject_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still pending",
                 cycle_count, results_pending);
        $display("Verification failed");
        $finish;
    end

    // result back-pressure: random stalls, plus long hold-offs on request
    initial begin
        i_out_stall  <= 1'b0;
        holds_served  = 0;
        hold_left     = 0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // one scan transaction, with random idle cycles ahead of it
    task automatic send_scan(input logic [SCAN_W-1:0] early, input logic [SCAN_W-1:0] late);
        while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_scan_early <= early;
        i_scan_late  <= late;
        do @(posedge i_clk); while (o_in_stall);
        scans_sent++;
    endtask

    // stop sending and let every predicted result come out
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0)
            @(posedge i_clk);
        repeat (DUT_LATENCY + 1) @(posedge i_clk);
    endtask

    // setup + access cycle; upper data bits are junk that must be ignored
    task automatic write_code(input logic idx, input logic [KEY_W-1:0] code);
        logic [DATA_W-1:0] wdata;
        wdata              = $urandom;
        wdata[KEY_W-1:0]   = code;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_CODE_ONE)
            code_one_now = code;
        else
            code_two_now = code;
    endtask

    task automatic set_codes(input logic [KEY_W-1:0] one, input logic [KEY_W-1:0] two);
        write_code(REG_CODE_ONE, one);
        write_code(REG_CODE_TWO, two);
        code_settings++;
    endtask

    // bit position of a code's key most of the time, otherwise any key
    function automatic int pick_key(input logic [KEY_W-1:0] code);
        int i;
        int hit;
        hit = -1;
        for (i = 0; i < SCAN_W; i++)
            if (KEY_ASCII[i] == code)
                hit = i;
        if (hit >= 0 && $urandom_range(3) != 0)
            return hit;
        return $urandom_range(SCAN_W - 1);
    endfunction

    // press, release, press, discard scan - with contact bounce and misfits
    task automatic enter_code_attempt();
        logic [SCAN_W-1:0] k1;
        logic [SCAN_W-1:0] k2;
        logic [SCAN_W-1:0] jitter;
        k1     = 16'h0001 << pick_key(code_one_now);
        k2     = 16'h0001 << pick_key(code_two_now);
        jitter = SCAN_W'($urandom);
        // bouncing early read still debounces to the key
        send_scan(($urandom_range(1) != 0) ? (k1 | jitter) : k1, k1);
        repeat ($urandom_range(2)) send_scan(k1, k1);
        if ($urandom_range(9) != 0)
            send_scan('0, jitter);
        repeat ($urandom_range(1)) send_scan('0, '0);
        send_scan(k2, ($urandom_range(1) != 0) ? (k2 | ~jitter) : k2);
        if ($urandom_range(9) == 0)
            send_scan(k2 | k1, k2 | k1);
        // discard scan
        if ($urandom_range(1) != 0)
            send_scan('0, '0);
        else
            send_scan(SCAN_W'($urandom), SCAN_W'($urandom));
    endtask

    task automatic send_noise();
        logic [SCAN_W-1:0] r;
        r = SCAN_W'($urandom);
        case ($urandom_range(3))
            0:       send_scan(SCAN_W'($urandom), SCAN_W'($urandom));
            1:       send_scan(r, r);
            2:       send_scan('0, '0);
            default: send_scan(16'h0001 << $urandom_range(SCAN_W - 1), r | ~r);
        endcase
    endtask

    task automatic run_directed();
        send_scan('0, '0);                            // nothing pressed
        send_scan('1, '1);                            // all keys: lowest wins
        send_scan('1, '1);                            // all held: none new
        send_scan('0, '0);
        send_scan('1, '0);                            // bounce either way
        send_scan('0, '1);
        send_scan(16'haaaa, 16'h5555);                // disjoint reads
        send_scan(16'h0001 << KEY_BIT_A, 16'h0001 << KEY_BIT_A);  // second key
        send_scan(16'h0001, 16'h0001);                // discard scan, reject
        send_scan('0, '0);
        send_scan(16'h0001 << KEY_BIT_ONE, 16'h0001 << KEY_BIT_ONE);
        send_scan('0, '0);
        send_scan(16'h0001 << KEY_BIT_TWO, 16'h0001 << KEY_BIT_TWO);
        // verdict is already taken: rewriting the codes must not change it
        wait_all_results();
        set_codes(7'h7f, 7'h00);
        send_scan('0, '0);                            // discard scan, accept
        send_scan(16'h0001 << KEY_BIT_ONE, 16'h0001 << KEY_BIT_ONE);
        send_scan('0, '0);
        send_scan(16'h0001 << KEY_BIT_TWO, 16'h0001 << KEY_BIT_TWO);
        send_scan(16'h0f0f, 16'hff0f);                // discard scan with keys
        send_scan(16'hff0f, 16'hffff);                // some new, some held
        send_scan('1, '1);
        send_scan('0, '0);
        wait_all_results();
    endtask

    initial begin
        int ph;
        int target;
        int r;
        bit pressure_done;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_scan_early   <= '0;
        i_scan_late    <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_requests   = 0;
        scans_sent      = 0;
        code_settings   = 1;
        code_one_now    = CODE_ONE_RESET;
        code_two_now    = CODE_TWO_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (ph = 0; ph < 4; ph++) begin
            wait_all_results();
            // code setting per phase
            r = $urandom_range(SCAN_W - 1);
            case (ph)
                0: set_codes(CODE_ONE_RESET, CODE_TWO_RESET);
                1: set_codes(KEY_ASCII[r], KEY_ASCII[$urandom_range(SCAN_W - 1)]);
                2: set_codes(KEY_W'($urandom_range(127)), KEY_W'($urandom_range(127)));
                default: set_codes(KEY_ASCII[r], KEY_ASCII[r]);
            endcase
            // handshake pressure per phase
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            pressure_done = 1'b0;
            target = scans_sent + PHASE_ITEMS;
            while (scans_sent < target) begin
                if (!pressure_done && scans_sent > target - PHASE_ITEMS / 2) begin
                    pressure_done = 1'b1;
                    if (ph == 1)
                        wait_all_results();   // sender pause until drained
                    else if (ph != 2)
                        hold_requests++;      // long receiver hold-off
                end
                if ($urandom_range(9) < 7)
                    enter_code_attempt();
                else
                    send_noise();
            end
        end

        wait_all_results();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d scans over directed cases and four stall phases, %0d code settings",
                 scans_sent, code_settings);
        $display("Checked %0d results: %0d accepted and %0d rejected verdicts",
                 result_count, accept_count, reject_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
